/* hdl/zfce_pkg.sv */
// shared types and constants of the zero-forcing carrier equaliser
`timescale 1ns / 1ps
package zfce_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_BIN     = 2'd0;
    localparam logic [1:0] REG_MAX_BIN     = 2'd1;
    localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;

    localparam int          EQ_SHIFT   = 12;
    localparam logic [15:0] GAIN_RESET = 16'd9385;
    localparam logic [9:0]  MIN_RESET  = 10'd0;
    localparam logic [9:0]  MAX_RESET  = 10'd1023;

    // pipeline layout: three front stages, divider, output register
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = 17;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    typedef logic signed [15:0] t_s16;

    // saturate a wide signed value to 16 bit signed
    function automatic t_s16 sat16(input logic signed [32:0] v);
        t_s16 res;
        if (v > 33'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -33'sd32768) begin
            res = -16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

/* hdl/zfce_div.sv */
// bit-per-stage restoring divider with saturated signed quotient
`timescale 1ns / 1ps
module zfce_div (
    input  logic               i_clk,
    input  logic [16:0]        i_en,
    input  logic signed [32:0] i_num,
    input  logic [15:0]        i_mag,
    output logic signed [15:0] o_quot
);

    logic [31:0] r_rem [0:16];
    logic [15:0] r_q   [0:16];
    logic [15:0] r_mag [0:16];
    logic        r_neg [0:16];
    logic        r_ovf [0:16];

    logic [32:0] w_abs;
    assign w_abs = i_num[32] ? 33'(-i_num) : 33'(i_num);

    // first stage: magnitude, sign and quotient overflow check
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= w_abs[31:0];
            r_q[0]   <= '0;
            r_mag[0] <= i_mag;
            r_neg[0] <= i_num[32];
            r_ovf[0] <= w_abs >= {1'b0, i_mag, 16'b0};
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= 16; k++) begin : g_bit
        localparam int B = 16 - k;
        logic [31:0] w_dsh;
        assign w_dsh = {16'b0, r_mag[k-1]} << B;
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                if (r_rem[k-1] >= w_dsh) begin
                    r_rem[k] <= r_rem[k-1] - w_dsh;
                    r_q[k]   <= r_q[k-1] | (16'd1 << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
                r_mag[k] <= r_mag[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // sign and saturation
    always_comb begin
        if (r_neg[16]) begin
            if (r_ovf[16] || r_q[16] > 16'd32768) begin
                o_quot = -16'sh8000;
            end else begin
                o_quot = 16'(-{1'b0, r_q[16]});
            end
        end else begin
            if (r_ovf[16] || r_q[16] > 16'd32767) begin
                o_quot = 16'sh7fff;
            end else begin
                o_quot = r_q[16];
            end
        end
    end

endmodule

/* hdl/zero_forcing_carrier_equalizer_core.sv */
// top level of the zero-forcing carrier equaliser
`timescale 1ns / 1ps
// Equalises one OFDM carrier per transaction. The input channel carries the
// carrier bin, the received sample and the channel estimate; the output
// channel carries the equalised sample, zero for bins outside min..max.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low. Configuration is a plain write port (min_bin, max_bin,
// output_gain), to be written while the block is idle; the block does not enforce it.
// From input transaction to output valid the data passes three stages
// of multiply/sum/gain, a 17-stage pipelined divider (one quotient bit per
// stage) and the output register. Throughput, unless stalled: one carrier per cycle.
// Each stage advances when it is empty or the next stage advances, so when
// the receiver stalls the pipeline fills its empty stages and then raises
// o_stall; nothing is lost or repeated. Synchronous reset empties the
// pipeline and restores the register defaults.
module zero_forcing_carrier_equalizer_core #(
    parameter int BIN_COUNT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [9:0]         i_carrier_bin,
    input  logic signed [15:0] i_sample_re,
    input  logic signed [15:0] i_sample_im,
    input  logic signed [15:0] i_chan_re,
    input  logic signed [15:0] i_chan_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_eq_re,
    output logic signed [15:0] o_eq_im
);

    localparam int N = zfce_pkg::PIPE_STAGES;
    localparam int F = zfce_pkg::FRONT_STAGES;

    logic [9:0]  r_min_bin;
    logic [9:0]  r_max_bin;
    logic [15:0] r_gain;

    logic [N-1:0] r_v;
    logic [N-1:0] r_band;
    logic [N-1:0] w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bin <= zfce_pkg::MIN_RESET;
            r_max_bin <= zfce_pkg::MAX_RESET;
            r_gain    <= zfce_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                zfce_pkg::REG_MIN_BIN:     r_min_bin <= i_cfg_data[9:0];
                zfce_pkg::REG_MAX_BIN:     r_max_bin <= i_cfg_data[9:0];
                zfce_pkg::REG_OUTPUT_GAIN: r_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain, back from the output register
    always_comb begin
        w_en[N-1] = !r_v[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end
    assign o_stall = !w_en[0];

    logic w_in_band;
    assign w_in_band = (32'(i_carrier_bin) < BIN_COUNT) && (i_carrier_bin >= r_min_bin)
                       && (i_carrier_bin <= r_max_bin);

    // valid and band flags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_band[0] <= w_in_band;
        end
        for (int k = 1; k < N; k++) begin
            if (w_en[k]) begin
                r_band[k] <= r_band[k-1];
            end
        end
    end

    // stage 0: the six products
    logic signed [31:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_p_cr, r_p_ci;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p_rr <= i_sample_re * i_chan_re;
            r_p_ii <= i_sample_im * i_chan_im;
            r_p_ir <= i_sample_im * i_chan_re;
            r_p_ri <= i_sample_re * i_chan_im;
            r_p_cr <= i_chan_re * i_chan_re;
            r_p_ci <= i_chan_im * i_chan_im;
        end
    end

    // stage 1: sums, floor shift, saturation
    logic signed [32:0] w_sum_re, w_sum_im, w_sum_mag;
    logic signed [15:0] w_mag_sat;
    assign w_sum_re  = 33'(r_p_rr) + 33'(r_p_ii);
    assign w_sum_im  = 33'(r_p_ir) - 33'(r_p_ri);
    assign w_sum_mag = 33'(r_p_cr) + 33'(r_p_ci);
    assign w_mag_sat = zfce_pkg::sat16(w_sum_mag >>> zfce_pkg::EQ_SHIFT);

    logic signed [15:0] r_re, r_im;
    logic [15:0]        r_mag1;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_re   <= zfce_pkg::sat16(w_sum_re >>> zfce_pkg::EQ_SHIFT);
            r_im   <= zfce_pkg::sat16(w_sum_im >>> zfce_pkg::EQ_SHIFT);
            r_mag1 <= (w_mag_sat == 16'sd0) ? 16'd1 : w_mag_sat;
        end
    end

    // stage 2: gain products
    logic signed [32:0] r_num_re, r_num_im;
    logic [15:0]        r_mag2;
    logic signed [16:0] w_gain;
    assign w_gain = {1'b0, r_gain};
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_num_re <= r_re * w_gain;
            r_num_im <= r_im * w_gain;
            r_mag2   <= r_mag1;
        end
    end

    // pipelined division by the magnitude
    logic signed [15:0] w_q_re, w_q_im;

    zfce_div u_div_re (
        .i_clk  (i_clk),
        .i_en   (w_en[F+16:F]),
        .i_num  (r_num_re),
        .i_mag  (r_mag2),
        .o_quot (w_q_re)
    );

    zfce_div u_div_im (
        .i_clk  (i_clk),
        .i_en   (w_en[F+16:F]),
        .i_num  (r_num_im),
        .i_mag  (r_mag2),
        .o_quot (w_q_im)
    );

    // output register, zero outside the band
    always_ff @(posedge i_clk) begin
        if (w_en[N-1]) begin
            o_eq_re <= r_band[N-2] ? w_q_re : 16'sd0;
            o_eq_im <= r_band[N-2] ? w_q_im : 16'sd0;
        end
    end
    assign o_valid = r_v[N-1];

endmodule
